// File: hw/rtl/pfx_pkg.sv
// shared types, constants and codes for the postfix evaluator
`default_nettype none
package pfx_pkg;
  localparam int unsigned StackDepth = 16;
  localparam int unsigned SpW = $clog2(StackDepth);
  localparam int unsigned CntW = $clog2(StackDepth + 1);
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW = $clog2(QDepth);

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_EMPTY     = 3'd1;
  localparam logic [2:0] ST_INVALID   = 3'd2;
  localparam logic [2:0] ST_UNDERFLOW = 3'd3;
  localparam logic [2:0] ST_OVERFLOW  = 3'd4;
  localparam logic [2:0] ST_DIVZERO   = 3'd5;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_STAR  = 8'h2a;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

  // one command from front to back
  typedef struct packed {
    logic        push;
    logic [31:0] num;
    logic        is_op;
    logic [1:0]  op;
    logic        invalid;
    logic        last;
  } cmd_t;
endpackage
`default_nettype wire

// File: hw/rtl/pfx_if.sv
// valid/ready channel interfaces
`default_nettype none
interface pfx_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       last;
  modport source (output valid, ch, last, input ready);
  modport sink (input valid, ch, last, output ready);
endinterface

interface pfx_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] value;
  logic [2:0]  status;
  modport source (output valid, value, status, input ready);
  modport sink (input valid, value, status, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/pfx_front.sv
// character classifier and number builder
`default_nettype none
module pfx_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  pfx_in_if.sink             in_ch,
  output pfx_pkg::cmd_t      cmd,
  output logic               cmd_valid,
  input  wire logic          cmd_ready
);
  import pfx_pkg::*;

  logic [31:0] accum_r;
  logic        in_num_r;
  logic        is_digit;
  logic [31:0] acc_ext;

  assign is_digit = (in_ch.ch >= CH_ZERO) && (in_ch.ch <= CH_NINE);
  assign acc_ext = (accum_r << 3) + (accum_r << 1) + {24'd0, in_ch.ch - CH_ZERO};

  // a digit without last needs no command
  assign cmd_valid = in_ch.valid && !(is_digit && !in_ch.last);
  assign in_ch.ready = cmd_ready || (is_digit && !in_ch.last);

  always_comb begin
    cmd = '0;
    cmd.last = in_ch.last;
    if (is_digit) begin
      cmd.push = 1'b1;
      cmd.num = acc_ext;
    end else begin
      cmd.push = in_num_r;
      cmd.num = accum_r;
      unique case (in_ch.ch)
        CH_PLUS:  begin cmd.is_op = 1'b1; cmd.op = OP_ADD; end
        CH_MINUS: begin cmd.is_op = 1'b1; cmd.op = OP_SUB; end
        CH_STAR:  begin cmd.is_op = 1'b1; cmd.op = OP_MUL; end
        CH_SLASH: begin cmd.is_op = 1'b1; cmd.op = OP_DIV; end
        CH_SPACE: ;
        default:  cmd.invalid = 1'b1;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accum_r <= '0;
      in_num_r <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      if (is_digit && !in_ch.last) begin
        accum_r <= acc_ext;
        in_num_r <= 1'b1;
      end else begin
        accum_r <= '0;
        in_num_r <= 1'b0;
      end
    end
  end
endmodule
`default_nettype wire

// File: hw/rtl/pfx_queue.sv
// small command fifo between front and back
`default_nettype none
module pfx_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire pfx_pkg::cmd_t wr_data,
  input  wire logic          wr_valid,
  output logic               wr_ready,
  output pfx_pkg::cmd_t      rd_data,
  output logic               rd_valid,
  input  wire logic          rd_ready
);
  import pfx_pkg::*;

  cmd_t             mem_r [QDepth];
  logic [QPtrW-1:0] wp_r, rp_r;
  logic [QPtrW:0]   cnt_r;
  logic             wr_en, rd_en;

  assign wr_ready = cnt_r != (QPtrW+1)'(QDepth);
  assign rd_valid = cnt_r != '0;
  assign rd_data = mem_r[rp_r];
  assign wr_en = wr_valid && wr_ready;
  assign rd_en = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wp_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (wr_en) wp_r <= wp_r + 1'b1;
      if (rd_en) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (QPtrW+1)'(wr_en) - (QPtrW+1)'(rd_en);
    end
  end

  a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (QPtrW+1)'(QDepth)) else $error("queue count beyond depth");
  a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == (QPtrW+1)'(QDepth) |-> !wr_ready) else $error("write allowed when full");
  a_empty_step: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == '0 && !wr_en |=> cnt_r == '0) else $error("count moved without write");
endmodule
`default_nettype wire

// File: hw/rtl/pfx_divider.sv
// iterative signed divider, one quotient bit per cycle
`default_nettype none
module pfx_divider (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [31:0] num,
  input  wire logic [31:0] den,
  output logic             done,
  output logic [31:0]      quot
);
  logic [31:0] q_r, d_r;
  logic [31:0] rem_r;
  logic [5:0]  cnt_r;
  logic        neg_r, busy_r;
  logic [32:0] trial;

  assign trial = {rem_r, q_r[31]} - {1'b0, d_r};
  assign done = busy_r && cnt_r == 6'd0;
  assign quot = neg_r ? 32'd0 - q_r : q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r <= 6'd32;
    end else if (busy_r) begin
      if (cnt_r == 6'd0) busy_r <= 1'b0;
      else cnt_r <= cnt_r - 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r <= num[31] ? 32'd0 - num : num;
      d_r <= den[31] ? 32'd0 - den : den;
      rem_r <= '0;
      neg_r <= num[31] ^ den[31];
    end else if (busy_r && cnt_r != 6'd0) begin
      if (!trial[32]) begin
        rem_r <= trial[31:0];
        q_r <= {q_r[30:0], 1'b1};
      end else begin
        rem_r <= {rem_r[30:0], q_r[31]};
        q_r <= {q_r[30:0], 1'b0};
      end
    end
  end
endmodule
`default_nettype wire

// File: hw/rtl/pfx_back.sv
// operand stack and operator execution
`default_nettype none
module pfx_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire pfx_pkg::cmd_t cmd,
  input  wire logic          cmd_valid,
  output logic               cmd_ready,
  pfx_out_if.source          out_res
);
  import pfx_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_EXEC = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;
  localparam logic [2:0] S_TOP  = 3'd5;

  logic [31:0]     stk_r [StackDepth];
  logic [CntW-1:0] cnt_r;
  logic [2:0]      err_r, state_r;
  logic [31:0]     rd_a_r, rd_b_r, res_r;
  logic [SpW-1:0]  ra_idx, rb_idx;
  logic            out_valid_r;
  logic [31:0]     out_value_r;
  logic [2:0]      out_status_r;
  logic            pend_push_r;
  logic            div_start, div_done;
  logic [31:0]     div_q;
  logic [31:0]     mul_r;
  logic            full;
  cmd_t            cmd_r;

  assign full = cnt_r == CntW'(StackDepth);
  assign ra_idx = SpW'(cnt_r - CntW'(1));
  assign rb_idx = SpW'(cnt_r - CntW'(2));
  assign cmd_ready = state_r == S_IDLE && !pend_push_r;
  assign out_res.valid = out_valid_r;
  assign out_res.value = out_value_r;
  assign out_res.status = out_status_r;
  assign div_start = state_r == S_EXEC && cmd_r.op == OP_DIV && rd_a_r != 32'd0;

  pfx_divider u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start),
    .num(rd_b_r), .den(rd_a_r), .done(div_done), .quot(div_q)
  );

  always_ff @(posedge clk) begin
    rd_a_r <= stk_r[ra_idx];
    rd_b_r <= stk_r[rb_idx];
    mul_r <= stk_r[rb_idx] * stk_r[ra_idx];
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && cmd_valid && cmd_ready && cmd.push && !full)
      stk_r[ra_idx + SpW'(1)] <= cmd.num;
    else if (pend_push_r && cnt_r != CntW'(StackDepth))
      stk_r[ra_idx + SpW'(1)] <= res_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r <= '0;
      err_r <= ST_OK;
      out_valid_r <= 1'b0;
      pend_push_r <= 1'b0;
    end else begin
      if (out_valid_r && out_res.ready) out_valid_r <= 1'b0;
      if (pend_push_r) begin
        pend_push_r <= 1'b0;
        cnt_r <= cnt_r + CntW'(1);
        state_r <= cmd_r.last ? S_FIN : S_IDLE;
      end else begin
        unique case (state_r)
          S_IDLE: if (cmd_valid && cmd_ready) begin
            cmd_r <= cmd;
            if (cmd.push) begin
              if (full) begin
                if (err_r < ST_UNDERFLOW) err_r <= ST_OVERFLOW;
              end else cnt_r <= cnt_r + CntW'(1);
            end
            state_r <= S_RD;
          end
          S_RD: begin
            if (cmd_r.is_op) begin
              if (cnt_r < CntW'(2)) begin
                if (err_r < ST_UNDERFLOW) err_r <= ST_UNDERFLOW;
                state_r <= cmd_r.last ? S_FIN : S_IDLE;
              end else state_r <= S_EXEC;
            end else begin
              if (cmd_r.invalid && err_r == ST_OK) err_r <= ST_INVALID;
              state_r <= cmd_r.last ? S_FIN : S_IDLE;
            end
          end
          S_EXEC: begin
            cnt_r <= cnt_r - CntW'(2);
            unique case (cmd_r.op)
              OP_ADD: begin res_r <= rd_b_r + rd_a_r; pend_push_r <= 1'b1; end
              OP_SUB: begin res_r <= rd_b_r - rd_a_r; pend_push_r <= 1'b1; end
              OP_MUL: begin res_r <= mul_r; pend_push_r <= 1'b1; end
              OP_DIV: begin
                if (rd_a_r == 32'd0) begin
                  if (err_r < ST_UNDERFLOW) err_r <= ST_DIVZERO;
                  res_r <= 32'd0;
                  pend_push_r <= 1'b1;
                end else state_r <= S_DIV;
              end
              default: ;
            endcase
          end
          S_DIV: if (div_done) begin
            res_r <= div_q;
            pend_push_r <= 1'b1;
          end
          S_FIN: state_r <= S_TOP;
          S_TOP: if (!out_valid_r) begin
            out_valid_r <= 1'b1;
            if (err_r >= ST_UNDERFLOW) begin
              out_value_r <= '0;
              out_status_r <= err_r;
            end else if (cnt_r == '0) begin
              out_value_r <= '0;
              out_status_r <= ST_EMPTY;
            end else begin
              out_value_r <= rd_a_r;
              out_status_r <= err_r;
            end
            cnt_r <= '0;
            err_r <= ST_OK;
            state_r <= S_IDLE;
          end
          default: state_r <= S_IDLE;
        endcase
      end
    end
  end

  a_err_range: assert property (@(posedge clk) disable iff (!rst_n)
    err_r <= ST_DIVZERO) else $error("error code out of range");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CntW'(StackDepth)) else $error("stack count beyond depth");
  a_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    $past(err_r) >= ST_UNDERFLOW && state_r != S_IDLE |-> err_r == $past(err_r))
    else $error("hard error not sticky");
endmodule
`default_nettype wire

// File: hw/rtl/postfix_expression_evaluator.sv
// top level of the postfix expression evaluator
// usage:
//   in channel takes one ascii character per transaction, with last marking
//   the final character of an expression
//   out channel gives one transaction per expression: value and status
//   digits that are not last are taken by the front end with no command
//   other characters pass through a four-entry command fifo to the back end
//   push or space: idle, read; add, sub or mul: also exec and result push
//   division uses a radix-2 iterative divider
//   the final report leaves through S_FIN and S_TOP after the last command
//   reset (rst_n low, synchronous) empties the stack, the fifo and errors
//   the stack has no reset; only written entries are read
//   a stalled out channel holds the result; the back end runs on until the
//   next report, while the front end keeps filling the fifo until it is full
`default_nettype none
module postfix_expression_evaluator (
  input  wire logic clk,
  input  wire logic rst_n,
  pfx_in_if.sink    in_ch,
  pfx_out_if.source out_res
);
  import pfx_pkg::*;

  cmd_t f_cmd, q_cmd;
  logic f_valid, f_ready, q_valid, q_ready;

  pfx_front u_front (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch),
    .cmd(f_cmd), .cmd_valid(f_valid), .cmd_ready(f_ready)
  );

  pfx_queue u_queue (
    .clk(clk), .rst_n(rst_n),
    .wr_data(f_cmd), .wr_valid(f_valid), .wr_ready(f_ready),
    .rd_data(q_cmd), .rd_valid(q_valid), .rd_ready(q_ready)
  );

  pfx_back u_back (
    .clk(clk), .rst_n(rst_n),
    .cmd(q_cmd), .cmd_valid(q_valid), .cmd_ready(q_ready),
    .out_res(out_res)
  );
endmodule
`default_nettype wire
